// File: design/jse_pkg.sv
// jse_pkg: shared types, constants and helpers of the JSON string escaper.
// Used by jse_if, jse_front, jse_queue, jse_back and json_string_escaper_unit.
// No dependencies.
package jse_pkg;

  // Byte counter width; the capacity is clamped to its range before it is compared
  localparam int LEN_BITS = 16;
  localparam int CAP_W    = 16;
  localparam int TLEN_W   = 16;
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STEP_W   = 3;
  localparam int CMP_W    = ((LEN_BITS > CAP_W) ? LEN_BITS : CAP_W) + 2;

  localparam logic [CMP_W-1:0]  CNT_MAX   = (CMP_W'(1) << LEN_BITS) - CMP_W'(1);
  localparam logic [CAP_W-1:0]  CAP_RESET = '1;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

  // Descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Characters
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;

  // Kind of output run a transaction produces
  typedef enum logic [2:0] {
    K_QUOTE,
    K_NOROOM,
    K_PLAIN,
    K_ESC2,
    K_ESC6
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data;   // raw byte, or escape letter for K_ESC2
    logic [LEN_BITS-1:0] base;   // count before the run
    logic                done;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

  typedef struct packed {
    logic  full;
    logic  not_empty;
    desc_t head;
  } qstat_t;

  // Lowercase hex digit
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] d);
    logic [BYTE_W-1:0] r;
    if (d < 4'd10) r = CH_ZERO + BYTE_W'(d);
    else           r = CH_LA + BYTE_W'(d) - BYTE_W'(10);
    return r;
  endfunction

endpackage

// File: design/jse_if.sv
// jse_if: handshake channels of the JSON string escaper (input, result, config).
// Depends on jse_pkg.
interface jse_in_if;
  logic                           valid;
  logic                           ready;
  logic [jse_pkg::CMD_W-1:0]      command;
  logic [jse_pkg::BYTE_W-1:0]     data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface jse_out_if;
  logic                           valid;
  logic                           ready;
  logic [jse_pkg::BYTE_W-1:0]     out_byte;
  logic                           last_of_run;
  logic                           string_done;
  logic                           no_room;
  logic [jse_pkg::TLEN_W-1:0]     total_length;

  modport source (output valid, output out_byte, output last_of_run, output string_done,
                  output no_room, output total_length, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input string_done,
                  input no_room, input total_length, output ready);
endinterface

interface jse_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [jse_pkg::CAP_W-1:0]      buffer_capacity;

  modport source (output valid, output buffer_capacity, input ready);
  modport sink   (input valid, input buffer_capacity, output ready);
endinterface

// File: design/jse_front.sv
// jse_front: accepts commands, tracks string state and byte count, classifies
// each byte and pushes one run descriptor per producing transaction.
// Depends on jse_pkg and jse_if.
module jse_front (
  input  logic               clk,
  input  logic               rst_n,
  jse_cfg_if.sink            cfg_ch,
  jse_in_if.sink             in_ch,
  input  jse_pkg::qstat_t    q_stat,
  output jse_pkg::push_t     q_push
);

  logic [jse_pkg::CAP_W-1:0]    cap_r;
  logic [jse_pkg::LEN_BITS-1:0] cnt_r, cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         instr_r, instr_nxt;

  logic                         acc;
  jse_pkg::kind_t               cls_kind;
  logic [jse_pkg::BYTE_W-1:0]   cls_data;
  logic [jse_pkg::STEP_W-1:0]   cls_n;
  logic [jse_pkg::CMP_W-1:0]    cap_ext, cap_eff, cnt_ext;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign acc          = in_ch.valid && !q_stat.full;

  // Capacity clamped to the counter range
  assign cap_ext = jse_pkg::CMP_W'(cap_r);
  assign cap_eff = (cap_ext > jse_pkg::CNT_MAX) ? jse_pkg::CNT_MAX : cap_ext;
  assign cnt_ext = jse_pkg::CMP_W'(cnt_r);

  // Byte classification
  always_comb begin
    cls_kind = jse_pkg::K_ESC2;
    cls_data = in_ch.data_byte;
    cls_n    = jse_pkg::STEP_W'(2);
    case (in_ch.data_byte)
      8'h22: cls_data = jse_pkg::CH_QUOTE;
      8'h5c: cls_data = jse_pkg::CH_BSL;
      8'h08: cls_data = 8'h62;  // b
      8'h0c: cls_data = 8'h66;  // f
      8'h0a: cls_data = 8'h6e;  // n
      8'h0d: cls_data = 8'h72;  // r
      8'h09: cls_data = 8'h74;  // t
      default: begin
        if (in_ch.data_byte < jse_pkg::CTRL_LIMIT) begin
          cls_kind = jse_pkg::K_ESC6;
          cls_n    = jse_pkg::STEP_W'(6);
        end else begin
          cls_kind = jse_pkg::K_PLAIN;
          cls_n    = jse_pkg::STEP_W'(1);
        end
      end
    endcase
  end

  // Command handling
  always_comb begin
    cnt_nxt          = cnt_r;
    ovf_nxt          = ovf_r;
    instr_nxt        = instr_r;
    q_push.valid     = 1'b0;
    q_push.desc.kind = jse_pkg::K_NOROOM;
    q_push.desc.data = in_ch.data_byte;
    q_push.desc.base = cnt_r;
    q_push.desc.done = 1'b1;
    if (acc) begin
      case (in_ch.command)
        jse_pkg::CMD_START: begin
          instr_nxt        = 1'b1;
          q_push.valid     = 1'b1;
          q_push.desc.base = '0;
          if (cap_eff < jse_pkg::CMP_W'(2)) begin
            ovf_nxt = 1'b1;
            cnt_nxt = '0;
          end else begin
            ovf_nxt          = 1'b0;
            cnt_nxt          = jse_pkg::LEN_BITS'(1);
            q_push.desc.kind = jse_pkg::K_QUOTE;
            q_push.desc.done = 1'b0;
          end
        end
        jse_pkg::CMD_END: begin
          if (instr_r) begin
            instr_nxt = 1'b0;
            if (ovf_r) begin
              ovf_nxt = 1'b0;
            end else begin
              q_push.valid = 1'b1;
              if (cnt_ext + jse_pkg::CMP_W'(1) <= cap_eff) begin
                cnt_nxt          = cnt_r + jse_pkg::LEN_BITS'(1);
                q_push.desc.kind = jse_pkg::K_QUOTE;
              end
            end
          end
        end
        jse_pkg::CMD_DATA: begin
          if (instr_r && !ovf_r) begin
            q_push.valid = 1'b1;
            if (cnt_ext + jse_pkg::CMP_W'(cls_n) + jse_pkg::CMP_W'(1) > cap_eff) begin
              ovf_nxt = 1'b1;
            end else begin
              cnt_nxt          = cnt_r + jse_pkg::LEN_BITS'(cls_n);
              q_push.desc.kind = cls_kind;
              q_push.desc.data = cls_data;
              q_push.desc.done = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= jse_pkg::CAP_RESET;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      instr_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) cap_r <= cfg_ch.buffer_capacity;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      instr_r <= instr_nxt;
    end
  end

endmodule

// File: design/jse_queue.sv
// jse_queue: small FIFO of run descriptors between front and back.
// Depends on jse_pkg.
module jse_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  jse_pkg::push_t   push,
  input  logic             pop,
  output jse_pkg::qstat_t  stat
);

  jse_pkg::desc_t              mem_r [jse_pkg::QDEPTH];
  logic [jse_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [jse_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push, do_pop;

  assign stat.full      = (cnt_r == jse_pkg::QCNT_W'(jse_pkg::QDEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign stat.head      = mem_r[rd_ptr_r];

  assign do_push = push.valid && !stat.full;
  assign do_pop  = pop && stat.not_empty;

  function automatic logic [jse_pkg::QPTR_W-1:0] ptr_inc(input logic [jse_pkg::QPTR_W-1:0] p);
    logic [jse_pkg::QPTR_W-1:0] r;
    if (p == jse_pkg::QPTR_W'(jse_pkg::QDEPTH - 1)) r = '0;
    else                                            r = p + jse_pkg::QPTR_W'(1);
    return r;
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.desc;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + jse_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - jse_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/jse_back.sv
// jse_back: expands the head descriptor into output bytes for the registered result
// channel, one per cycle while that channel is not stalled.
// Depends on jse_pkg and jse_if.
module jse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jse_pkg::qstat_t  q_stat,
  output logic             pop,
  jse_out_if.source        out_ch
);

  logic [jse_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [jse_pkg::STEP_W-1:0]   last_idx;
  logic                         load, is_last;
  logic [jse_pkg::BYTE_W-1:0]   byte_d;
  logic [jse_pkg::LEN_BITS-1:0] len_d;
  logic [jse_pkg::CMP_W-1:0]    len_ext;
  jse_pkg::desc_t               hd;

  logic                         out_valid_r;
  logic [jse_pkg::BYTE_W-1:0]   out_byte_r;
  logic                         out_last_r, out_done_r, out_nr_r;
  logic [jse_pkg::TLEN_W-1:0]   out_len_r;

  assign hd      = q_stat.head;
  assign load    = q_stat.not_empty && (!out_valid_r || out_ch.ready);
  assign is_last = (step_r == last_idx);
  assign pop     = load && is_last;
  assign step_nxt = is_last ? '0 : step_r + jse_pkg::STEP_W'(1);

  // Byte selection for the current step
  always_comb begin
    last_idx = '0;
    byte_d   = hd.data;
    case (hd.kind)
      jse_pkg::K_QUOTE:  byte_d = jse_pkg::CH_QUOTE;
      jse_pkg::K_NOROOM: byte_d = '0;
      jse_pkg::K_PLAIN:  byte_d = hd.data;
      jse_pkg::K_ESC2: begin
        last_idx = jse_pkg::STEP_W'(1);
        byte_d   = (step_r == '0) ? jse_pkg::CH_BSL : hd.data;
      end
      jse_pkg::K_ESC6: begin
        last_idx = jse_pkg::STEP_W'(5);
        case (step_r)
          3'd0:    byte_d = jse_pkg::CH_BSL;
          3'd1:    byte_d = jse_pkg::CH_U;
          3'd2:    byte_d = jse_pkg::CH_ZERO;
          3'd3:    byte_d = jse_pkg::CH_ZERO;
          3'd4:    byte_d = jse_pkg::hex_digit(hd.data[7:4]);
          default: byte_d = jse_pkg::hex_digit(hd.data[3:0]);
        endcase
      end
      default: ;
    endcase
  end

  // Running length: count before a no-room result, otherwise including this byte
  assign len_d   = (hd.kind == jse_pkg::K_NOROOM) ? hd.base
                 : hd.base + jse_pkg::LEN_BITS'(step_r) + jse_pkg::LEN_BITS'(1);
  assign len_ext = jse_pkg::CMP_W'(len_d);

  // Step counter and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r      <= step_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_d;
      out_last_r <= is_last;
      out_done_r <= hd.done;
      out_nr_r   <= (hd.kind == jse_pkg::K_NOROOM);
      out_len_r  <= len_ext[jse_pkg::TLEN_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.string_done  = out_done_r;
  assign out_ch.no_room      = out_nr_r;
  assign out_ch.total_length = out_len_r;

endmodule

// File: design/json_string_escaper_unit.sv
// json_string_escaper_unit: top level of the JSON string escaper.
// Depends on jse_pkg, jse_if, jse_front, jse_queue and jse_back.
//
//   channel  | dir | handshake     | payload
//   cfg_ch   | in  | valid / ready | buffer_capacity[15:0]
//   in_ch    | in  | valid / ready | command[1:0], data_byte[7:0]
//   out_ch   | out | valid / ready | out_byte, last_of_run, string_done, no_room,
//            |     |               | total_length[15:0]
//
// Each producing transaction yields one result byte (plain, quote, no room), two for
// two-byte escapes and six for \u00XX escapes, one byte per cycle unless stalled.
// A 4-entry descriptor queue sits between the classifying front end and the back end;
// in_ch.ready drops only while it is full. cfg_ch.ready is always high.
// Reset is synchronous (rst_n low): no string open, count 0, capacity 65535.
// Results sit in an output register and hold while out_ch.ready is low.
module json_string_escaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  jse_cfg_if.sink    cfg_ch,
  jse_in_if.sink     in_ch,
  jse_out_if.source  out_ch
);

  jse_pkg::push_t  q_push;
  jse_pkg::qstat_t q_stat;
  logic            q_pop;

  jse_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  jse_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .stat  (q_stat)
  );

  jse_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// File: dv/json_string_escaper_unit_tb.sv
`timescale 1ns / 100ps
// json_string_escaper_unit_tb: self-checking bench for the JSON string escaper.
// Predicts the quoted, escaped byte stream per accepted command and checks each result.
// Depends on jse_pkg, jse_if and json_string_escaper_unit.
module json_string_escaper_unit_tb;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_ITEMS    = 60;
  localparam int MAX_PRINTED     = 100;

  localparam logic [jse_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam longint unsigned COUNT_MASK = (64'd1 << jse_pkg::LEN_BITS) - 64'd1;

  // One output byte as seen on the result channel
  typedef struct packed {
    logic [jse_pkg::BYTE_W-1:0] chr;
    logic                       last;
    logic                       done;
    logic                       no_room;
    logic [jse_pkg::TLEN_W-1:0] tlen;
  } esc_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  jse_cfg_if cfg_ch ();
  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted escaper state
  logic [jse_pkg::CAP_W-1:0] cap_model = jse_pkg::CAP_RESET;
  longint unsigned  str_count    = 0;
  bit               str_open     = 1'b0;
  bit               str_overflow = 1'b0;

  esc_byte_t expected_bytes[$];
  string     hex_chars = "0123456789abcdef";

  int error_count   = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;
  int hold_off_len  = 0;
  bit idle_enable   = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic expect_byte(input logic [jse_pkg::BYTE_W-1:0] chr, input logic last,
                             input logic done, input logic no_room);
    esc_byte_t r;
    r.chr     = chr;
    r.last    = last;
    r.done    = done;
    r.no_room = no_room;
    r.tlen    = jse_pkg::TLEN_W'(str_count);
    expected_bytes.push_back(r);
  endtask

  task automatic predict_escape(input logic [jse_pkg::CMD_W-1:0] cmd,
                                input logic [jse_pkg::BYTE_W-1:0] data);
    logic [jse_pkg::BYTE_W-1:0] seq [0:5];
    longint unsigned   limit;
    int                n;
    int                k;
    limit = (longint'(cap_model) < COUNT_MASK) ? longint'(cap_model) : COUNT_MASK;
    n = 0;
    if (cmd == jse_pkg::CMD_START) begin
      // start abandons any open string
      str_open     = 1'b1;
      str_overflow = 1'b0;
      str_count    = 0;
      if (limit < 2) begin
        str_overflow = 1'b1;
        expect_byte('0, 1'b1, 1'b1, 1'b1);
      end else begin
        str_count = 1;
        expect_byte(jse_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
      end
    end else if (cmd == jse_pkg::CMD_END) begin
      if (str_open) begin
        str_open = 1'b0;
        if (str_overflow) begin
          str_overflow = 1'b0;
        end else if (str_count + 1 > limit) begin
          expect_byte('0, 1'b1, 1'b1, 1'b1);
        end else begin
          str_count = (str_count + 1) & COUNT_MASK;
          expect_byte(jse_pkg::CH_QUOTE, 1'b1, 1'b1, 1'b0);
        end
      end
    end else if (cmd == jse_pkg::CMD_DATA && str_open && !str_overflow) begin
      seq[0] = jse_pkg::CH_BSL;
      case (data)
        jse_pkg::CH_QUOTE: begin seq[1] = jse_pkg::CH_QUOTE; n = 2; end
        jse_pkg::CH_BSL:   begin seq[1] = jse_pkg::CH_BSL;   n = 2; end
        8'h08:    begin seq[1] = "b";      n = 2; end
        8'h0c:    begin seq[1] = "f";      n = 2; end
        8'h0a:    begin seq[1] = "n";      n = 2; end
        8'h0d:    begin seq[1] = "r";      n = 2; end
        8'h09:    begin seq[1] = "t";      n = 2; end
        default: begin
          if (data < jse_pkg::CTRL_LIMIT) begin
            seq[1] = "u";
            seq[2] = "0";
            seq[3] = "0";
            seq[4] = hex_chars[data[7:4]];
            seq[5] = hex_chars[data[3:0]];
            n = 6;
          end else begin
            seq[0] = data;
            n = 1;
          end
        end
      endcase
      // one byte always stays spare for the closing quote
      if (str_count + longint'(n) + 1 > limit) begin
        str_overflow = 1'b1;
        expect_byte('0, 1'b1, 1'b1, 1'b1);
      end else begin
        for (k = 0; k < n; k++) begin
          str_count = (str_count + 1) & COUNT_MASK;
          expect_byte(seq[k], k == n - 1, 1'b0, 1'b0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic send_command(input logic [jse_pkg::CMD_W-1:0] cmd,
                              input logic [jse_pkg::BYTE_W-1:0] data);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    predict_escape(cmd, data);
    items_sent++;
  endtask

  // Capacity is only changed once the escaper has gone quiet
  task automatic write_capacity(input logic [jse_pkg::CAP_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.buffer_capacity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_model = value;
  endtask

  function automatic logic [jse_pkg::BYTE_W-1:0] pick_string_byte();
    logic [jse_pkg::BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0, 1, 2: b = jse_pkg::BYTE_W'($urandom_range(8'h20, 8'hff));
      3: begin
        case ($urandom_range(0, 6))
          0:       b = jse_pkg::CH_QUOTE;
          1:       b = jse_pkg::CH_BSL;
          2:       b = 8'h08;
          3:       b = 8'h0c;
          4:       b = 8'h0a;
          5:       b = 8'h0d;
          default: b = 8'h09;
        endcase
      end
      4:       b = jse_pkg::BYTE_W'($urandom_range(0, 8'h1f));
      default: b = jse_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic logic [jse_pkg::CAP_W-1:0] pick_capacity();
    logic [jse_pkg::CAP_W-1:0] c;
    case ($urandom_range(0, 4))
      0:       c = jse_pkg::CAP_W'($urandom_range(0, 3));
      1, 2:    c = jse_pkg::CAP_W'($urandom_range(4, 40));
      3:       c = '1;
      default: c = jse_pkg::CAP_W'($urandom());
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < MAX_PRINTED)
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    esc_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result, out_byte", out_ch.out_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.chr)
          report_mismatch("out_byte", out_ch.out_byte, want.chr);
        if (out_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", out_ch.last_of_run, want.last);
        if (out_ch.string_done !== want.done)
          report_mismatch("string_done", out_ch.string_done, want.done);
        if (out_ch.no_room !== want.no_room)
          report_mismatch("no_room", out_ch.no_room, want.no_room);
        if (out_ch.total_length !== want.tlen)
          report_mismatch("total_length", out_ch.total_length, want.tlen);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain bytes at the edges, every two-byte escape and some \u00XX escapes
  task automatic test_escape_classes();
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h41);
    send_command(jse_pkg::CMD_DATA, 8'hff);
    send_command(jse_pkg::CMD_DATA, 8'h20);
    send_command(jse_pkg::CMD_DATA, 8'h1f);
    send_command(jse_pkg::CMD_DATA, 8'h00);
    send_command(jse_pkg::CMD_DATA, jse_pkg::CH_QUOTE);
    send_command(jse_pkg::CMD_DATA, jse_pkg::CH_BSL);
    send_command(jse_pkg::CMD_DATA, 8'h08);
    send_command(jse_pkg::CMD_DATA, 8'h0c);
    send_command(jse_pkg::CMD_DATA, 8'h0a);
    send_command(jse_pkg::CMD_DATA, 8'h0d);
    send_command(jse_pkg::CMD_DATA, 8'h09);
    send_command(jse_pkg::CMD_DATA, 8'h1b);
    send_command(jse_pkg::CMD_END, 8'hff);
  endtask

  // Commands outside a string, the reserved code, and a restart mid-string
  task automatic test_ignored_commands();
    send_command(jse_pkg::CMD_DATA, 8'h61);
    send_command(jse_pkg::CMD_END, 8'h00);
    send_command(CMD_RESERVED, 8'hff);
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(CMD_RESERVED, 8'h62);
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h7a);
    send_command(jse_pkg::CMD_END, 8'h00);
  endtask

  // Capacity too small to open, exactly full, and lowered while a string is open
  task automatic test_capacity_edges();
    write_capacity('0);
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h61);
    send_command(jse_pkg::CMD_END, 8'h00);
    write_capacity(jse_pkg::CAP_W'(2));
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_END, 8'h00);
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h61);
    send_command(jse_pkg::CMD_END, 8'h00);
    write_capacity(jse_pkg::CAP_W'(8));
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h01);
    send_command(jse_pkg::CMD_END, 8'h00);
    write_capacity('1);
    send_command(jse_pkg::CMD_START, 8'h00);
    send_command(jse_pkg::CMD_DATA, 8'h78);
    send_command(jse_pkg::CMD_DATA, 8'h79);
    write_capacity(jse_pkg::CAP_W'(3));
    send_command(jse_pkg::CMD_END, 8'h00);
  endtask

  // Long receiver hold-off while escapes keep coming, so the input stalls
  task automatic test_output_stall();
    int i;
    write_capacity('1);
    idle_enable  = 1'b0;
    hold_off_len = HOLD_OFF_CYCLES;
    send_command(jse_pkg::CMD_START, 8'h00);
    for (i = 0; i < 14; i++)
      send_command(jse_pkg::CMD_DATA,
                   (i % 2 == 0) ? jse_pkg::BYTE_W'(i) : jse_pkg::CH_QUOTE);
    send_command(jse_pkg::CMD_END, 8'h00);
    idle_enable = 1'b1;
  endtask

  // Mostly well-formed strings with random content over random capacities,
  // plus stray commands and strings left without an end
  task automatic test_random_strings(input int num_items);
    int stop_at;
    int len;
    stop_at = items_sent + num_items;
    while (items_sent < stop_at) begin
      write_capacity(pick_capacity());
      repeat (4) begin
        if ($urandom_range(0, 9) == 0) begin
          send_command(jse_pkg::CMD_W'($urandom_range(0, 3)),
                       jse_pkg::BYTE_W'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(0, 10);
          send_command(jse_pkg::CMD_START, jse_pkg::BYTE_W'($urandom_range(0, 255)));
          repeat (len) send_command(jse_pkg::CMD_DATA, pick_string_byte());
          if ($urandom_range(0, 9) != 0)
            send_command(jse_pkg::CMD_END, jse_pkg::BYTE_W'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.command          <= jse_pkg::CMD_START;
    in_ch.data_byte        <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.buffer_capacity <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_escape_classes();
    test_ignored_commands();
    test_capacity_edges();
    test_output_stall();
    test_random_strings(RANDOM_ITEMS);

    // closing stretch without idling on either side
    idle_enable = 1'b0;
    test_random_strings(30);

    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
design/jse_pkg.sv
design/jse_if.sv
design/jse_front.sv
design/jse_queue.sv
design/jse_back.sv
design/json_string_escaper_unit.sv
dv/json_string_escaper_unit_tb.sv
